### rtl/ptd_pkg.sv
// types and constants shared by the point to triangle distance block
package ptd_pkg;

  localparam int DIST_W = 34;
  localparam int REG_W  = 2;

  localparam logic [REG_W-1:0] RGN_INSIDE = 2'd0;
  localparam logic [REG_W-1:0] RGN_AB     = 2'd1;
  localparam logic [REG_W-1:0] RGN_AC     = 2'd2;
  localparam logic [REG_W-1:0] RGN_BC     = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] region;
    logic             degenerate;
  } ptd_cls_t;

endpackage

### rtl/ptd_front.sv
// front end: edge vectors, dot products, barycentric sign tests and edge pick
module ptd_front #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] a_i [3],
  input  logic signed [CW-1:0] b_i [3],
  input  logic signed [CW-1:0] c_i [3],
  input  logic signed [CW-1:0] p_i [3],
  output logic                 f_valid,
  input  logic                 f_ready,
  output logic signed [CW:0]   f_s [3],
  output logic signed [CW:0]   f_q [3],
  output ptd_pkg::ptd_cls_t    f_cls
);
  import ptd_pkg::*;

  localparam int EW = CW + 1;
  localparam int DW = 2 * EW + 2;
  localparam int PW = 2 * DW;
  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic          adv;

  logic signed [EW-1:0] e0_r [3], e1_r [3], w_r [3];
  logic signed [EW-1:0] bc_r [3], bp_r [3];
  logic signed [DW-1:0] d00_r, d01_r, d02_r, d11_r, d12_r;
  logic signed [EW-1:0] e0_2 [3], e1_2 [3], w_2 [3], bc_2 [3], bp_2 [3];
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [EW-1:0] e0_3 [3], e1_3 [3], w_3 [3], bc_3 [3], bp_3 [3];
  logic signed [PW+1:0] den, un, vn, sumuv;
  logic [REG_W-1:0]     rgn_nxt;
  logic                 dg_nxt;
  ptd_cls_t             cls_r;
  logic signed [EW-1:0] s_r [3], q_r [3];

  assign adv      = !v_r[NS-1] || f_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  assign den   = PW'(m0_r) - PW'(m1_r);
  assign un    = PW'(m2_r) - PW'(m3_r);
  assign vn    = PW'(m4_r) - PW'(m5_r);
  assign sumuv = un + vn - den;

  always_comb begin
    dg_nxt = (den == '0);
    if (dg_nxt) begin
      rgn_nxt = RGN_BC;
    end else if (!un[PW+1] && !vn[PW+1] && sumuv[PW+1]) begin
      rgn_nxt = RGN_INSIDE;
    end else if (un[PW+1]) begin
      rgn_nxt = RGN_AB;
    end else if (vn[PW+1]) begin
      rgn_nxt = RGN_AC;
    end else begin
      rgn_nxt = RGN_BC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= EW'(c_i[i]) - EW'(a_i[i]);
        e1_r[i] <= EW'(b_i[i]) - EW'(a_i[i]);
        w_r[i]  <= EW'(p_i[i]) - EW'(a_i[i]);
        bc_r[i] <= EW'(c_i[i]) - EW'(b_i[i]);
        bp_r[i] <= EW'(p_i[i]) - EW'(b_i[i]);
      end
      d00_r <= DW'(e0_r[0]*e0_r[0]) + DW'(e0_r[1]*e0_r[1]) + DW'(e0_r[2]*e0_r[2]);
      d01_r <= DW'(e0_r[0]*e1_r[0]) + DW'(e0_r[1]*e1_r[1]) + DW'(e0_r[2]*e1_r[2]);
      d02_r <= DW'(e0_r[0]*w_r[0]) + DW'(e0_r[1]*w_r[1]) + DW'(e0_r[2]*w_r[2]);
      d11_r <= DW'(e1_r[0]*e1_r[0]) + DW'(e1_r[1]*e1_r[1]) + DW'(e1_r[2]*e1_r[2]);
      d12_r <= DW'(e1_r[0]*w_r[0]) + DW'(e1_r[1]*w_r[1]) + DW'(e1_r[2]*w_r[2]);
      e0_2 <= e0_r; e1_2 <= e1_r; w_2 <= w_r; bc_2 <= bc_r; bp_2 <= bp_r;
      m0_r <= PW'(d00_r * d11_r);
      m1_r <= PW'(d01_r * d01_r);
      m2_r <= PW'(d11_r * d02_r);
      m3_r <= PW'(d01_r * d12_r);
      m4_r <= PW'(d00_r * d12_r);
      m5_r <= PW'(d01_r * d02_r);
      e0_3 <= e0_2; e1_3 <= e1_2; w_3 <= w_2; bc_3 <= bc_2; bp_3 <= bp_2;
      cls_r <= '{region: rgn_nxt, degenerate: dg_nxt};
      case (rgn_nxt)
        RGN_AB: begin
          s_r <= e1_3; q_r <= w_3;
        end
        RGN_AC: begin
          s_r <= e0_3; q_r <= w_3;
        end
        default: begin
          s_r <= bc_3; q_r <= bp_3;
        end
      endcase
    end
  end

  assign f_valid = v_r[NS-1];
  assign f_s     = s_r;
  assign f_q     = q_r;
  assign f_cls   = cls_r;

endmodule

### rtl/ptd_queue.sv
// short fifo between front and back ends
module ptd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem_r [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;
  logic         wr, rd;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(cnt_r == 3'd4 && wr))
    else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(cnt_r == 3'd0 && rd))
    else $error("queue underrun");

endmodule

### rtl/ptd_back.sv
// back end: clamped projection onto the chosen edge with pipelined divider
module ptd_back #(
  parameter int CW = 16,
  parameter int QB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 b_valid,
  output logic                 b_ready,
  input  logic signed [CW:0]   b_s [3],
  input  logic signed [CW:0]   b_q [3],
  input  ptd_pkg::ptd_cls_t    b_cls,
  output logic                 o_valid,
  input  logic                 o_ready,
  output logic [ptd_pkg::DIST_W-1:0] o_dist,
  output ptd_pkg::ptd_cls_t    o_cls
);
  import ptd_pkg::*;

  localparam int EW = CW + 1;
  localparam int DW = 2 * EW + 2;
  localparam int RW = DW + 1;
  localparam int NS = QB + 5;
  localparam int XW = EW + QB + 2;
  localparam int SW = 2 * XW + 2;

  typedef struct packed {
    logic [1:0]     kind;
    ptd_cls_t       cls;
    logic [DW-1:0]  den;
    logic [RW-1:0]  rem;
    logic [QB-1:0]  t;
    logic [3*EW-1:0] s;
    logic [3*EW-1:0] q;
    logic [DW-1:0]  dd;
  } st_t;

  localparam logic [1:0] K_Q = 2'd0;
  localparam logic [1:0] K_E = 2'd1;
  localparam logic [1:0] K_P = 2'd2;

  logic [NS-1:0] v_r;
  logic          adv;
  st_t           st_r [NS];
  st_t           st_nxt [NS];
  logic signed [DW-1:0] c1, c2, qq, ee;
  logic signed [EW:0]   e [3];
  st_t           s0;
  logic signed [XW-1:0] dd [3], rnd [3];
  logic signed [EW-1:0] sv [3], qv [3];
  logic signed [SW-1:0] acc;
  logic [SW-1:0]        acc_u;
  logic [DW-1:0]        dist_r;

  assign adv     = !v_r[NS-1] || o_ready;
  assign b_ready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) e[i] = (EW+1)'(b_q[i]) - (EW+1)'(b_s[i]);
    c1 = DW'(b_q[0]*b_s[0]) + DW'(b_q[1]*b_s[1]) + DW'(b_q[2]*b_s[2]);
    c2 = DW'(b_s[0]*b_s[0]) + DW'(b_s[1]*b_s[1]) + DW'(b_s[2]*b_s[2]);
    qq = DW'(b_q[0]*b_q[0]) + DW'(b_q[1]*b_q[1]) + DW'(b_q[2]*b_q[2]);
    ee = DW'(e[0]*e[0]) + DW'(e[1]*e[1]) + DW'(e[2]*e[2]);
    s0 = '0;
    s0.cls = b_cls;
    s0.s = {b_s[2], b_s[1], b_s[0]};
    s0.q = {b_q[2], b_q[1], b_q[0]};
    s0.den = c2;
    s0.rem = RW'(c1);
    if (b_cls.region == RGN_INSIDE) begin
      s0.kind = K_Q; s0.dd = '0;
    end else if (c1 <= 0) begin
      s0.kind = K_Q; s0.dd = qq;
    end else if (c2 <= c1) begin
      s0.kind = K_E; s0.dd = ee;
    end else begin
      s0.kind = K_P;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], b_valid};
    end
  end

  // one quotient bit per stage
  always_comb begin
    st_nxt[0] = s0;
    for (int k = 1; k < NS; k++) st_nxt[k] = st_r[k-1];
    for (int k = 1; k <= QB; k++) begin
      if ({st_r[k-1].rem, 1'b0} >= (RW+1)'(st_r[k-1].den)) begin
        st_nxt[k].rem = RW'({st_r[k-1].rem, 1'b0} - (RW+1)'(st_r[k-1].den));
        st_nxt[k].t   = {st_r[k-1].t[QB-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = RW'({st_r[k-1].rem, 1'b0});
        st_nxt[k].t   = {st_r[k-1].t[QB-2:0], 1'b0};
      end
    end
    st_nxt[QB+2].s  = {rnd[2][EW-1:0], rnd[1][EW-1:0], rnd[0][EW-1:0]};
    st_nxt[QB+3].dd = DW'(acc_u);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= st_nxt;
      dist_r <= st_r[QB+3].dd;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = st_r[QB+1].s[i*EW +: EW];
      qv[i] = st_r[QB+1].q[i*EW +: EW];
      dd[i] = XW'(sv[i] * $signed({1'b0, st_r[QB+1].t}))
            - (XW'(qv[i]) <<< QB) + (XW'(1) <<< (QB - 1));
      rnd[i] = dd[i] >>> QB;
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = acc + SW'($signed(st_r[QB+2].s[i*EW +: EW])
                    * $signed(st_r[QB+2].s[i*EW +: EW]));
    end
    if (st_r[QB+2].kind == K_P) acc_u = acc;
    else acc_u = SW'(st_r[QB+2].dd);
  end

  assign o_valid = v_r[NS-1];
  assign o_dist  = (|dist_r[DW-1:DIST_W]) ? {DIST_W{1'b1}} : dist_r[DIST_W-1:0];
  assign o_cls   = st_r[NS-1].cls;

  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_cls.region == RGN_INSIDE |-> o_dist == '0)
    else $error("inside gives nonzero distance");
  a_degen_bc: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_cls.degenerate |-> o_cls.region == RGN_BC)
    else $error("degenerate not on edge bc");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(o_dist) && $stable(o_cls))
    else $error("output word changed while stalled");

endmodule

### rtl/point_triangle_distance_sq.sv
// top level: point to triangle squared distance
//  channel | ports                                  | contents
//  in      | in_tvalid in_tready in_tdata           | ax ay az bx by bz cx cy cz px py pz
//  out     | out_tvalid out_tready out_tdata out_tuser | dist_sq, tuser region degenerate
// one word per cycle sustained while out_tready stays high; out_tvalid rises once the
// word has passed four front stages, the queue and QUOT_BITS + 5 back stages
// reset clears valid bits, queue pointers and the queue count only
// in_tready drops only while the queue is full and the last front stage holds a word;
// out_tready low on a valid word stalls the back pipe; the queue absorbs up to four words
module point_triangle_distance_sq #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  parameter int QUOT_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [12*COORD_WIDTH-1:0] in_tdata,   // ax ay az bx by bz cx cy cz px py pz
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [39:0]              out_tdata,  // dist_sq, zero fill
  output logic [2:0]               out_tuser   // region, degenerate
);
  import ptd_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = CW + 1;
  localparam int QW = 6 * EW + 3;
  localparam int FB = FRAC_BITS;

  logic signed [CW-1:0] a [3], b [3], c [3], p [3];
  logic                 f_valid, f_ready, q_valid, q_ready;
  logic signed [EW-1:0] f_s [3], f_q [3], q_s [3], q_q [3];
  ptd_cls_t             f_cls, q_cls, o_cls;
  logic [QW-1:0]        wdat, rdat;
  logic [DIST_W-1:0]    o_dist;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = in_tdata[(i)*CW +: CW];
      b[i] = in_tdata[(3+i)*CW +: CW];
      c[i] = in_tdata[(6+i)*CW +: CW];
      p[i] = in_tdata[(9+i)*CW +: CW] + CW'(FB - FB);
    end
  end

  ptd_front #(.CW(CW)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .a_i(a), .b_i(b), .c_i(c), .p_i(p),
    .f_valid, .f_ready, .f_s, .f_q, .f_cls
  );

  assign wdat = {f_cls, f_s[2], f_s[1], f_s[0], f_q[2], f_q[1], f_q[0]};

  ptd_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(wdat),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(rdat)
  );

  assign {q_cls, q_s[2], q_s[1], q_s[0], q_q[2], q_q[1], q_q[0]} = rdat;

  ptd_back #(.CW(CW), .QB(QUOT_BITS)) u_back (
    .clk, .rst_n, .b_valid(q_valid), .b_ready(q_ready),
    .b_s(q_s), .b_q(q_q), .b_cls(q_cls),
    .o_valid(out_tvalid), .o_ready(out_tready), .o_dist, .o_cls
  );

  assign out_tdata = {6'd0, o_dist};
  assign out_tuser = {o_cls.degenerate, o_cls.region};

endmodule
